### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that run on clk and are switched off while rst_n is low.
`define ACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that also hold while reset is applied.
`define ACM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/acm_pkg.sv
package acm_pkg;

  localparam int FRAMES    = 4096;
  localparam int TRACKS    = 2;
  localparam int LANES     = 2 * TRACKS;
  localparam int SAMPLE_W  = 24;
  localparam int FRAC_W    = SAMPLE_W - 4;
  localparam int ADDR_W    = $clog2(FRAMES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int FRAME_W   = TRACKS * SAMPLE_W;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int NUM_W     = 50;
  localparam int DEN_W     = 31;
  localparam int ITER_W    = 6;

  localparam logic signed [SAMPLE_W-1:0] ONE_Q = SAMPLE_W'(1 << FRAC_W);
  localparam logic signed [SAMPLE_W-1:0] SMAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] KNEE_Q       = SAMPLE_W'(525533);
  localparam logic [SAMPLE_W-1:0] PEAK_LIMIT   = SAMPLE_W'(1038090);
  localparam logic [DEN_W-1:0]    KNEE_99      = DEN_W'(99 * 525533);
  localparam logic [19:0]         COMP_M       = 20'(1048576 - 525533);

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_CLIP      = 3'd1,
    MODE_SCALE     = 3'd2,
    MODE_CHAN      = 3'd3,
    MODE_ANTI      = 3'd4,
    MODE_CHAN_ANTI = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_RETURNED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    K_PASS = 3'd0,
    K_CLIP = 3'd1,
    K_DIV  = 3'd2,
    K_COMP = 3'd3,
    K_ONE  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [DEN_W-1:0] divisor;
  } lane_cmd_t;

endpackage

### sv/acm_ram.sv
module acm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/acm_lane.sv
module acm_lane import acm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lane_cmd_t                  cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0]        peak,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } lstate_t;

  lstate_t                    state_r, state_nxt;
  kind_t                      kind_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [SAMPLE_W-1:0]        mag_r;
  logic [DEN_W-1:0]           n_r;
  logic [DEN_W-1:0]           den_r;
  logic [NUM_W-1:0]           num_r;
  logic [DEN_W-1:0]           rem_r;
  logic [ITER_W-1:0]          cnt_r;

  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        a_cl;
  logic [DEN_W-1:0]           peak100;
  logic [DEN_W:0]             rem_sh;
  logic                       qbit;
  logic [SAMPLE_W-1:0]        y;

  assign mag     = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : sample;
  assign a_cl    = (mag > peak) ? peak : mag;
  assign peak100 = DEN_W'({{(DEN_W-SAMPLE_W){1'b0}}, peak} * DEN_W'(100));
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   if (cnt_r == ITER_W'(NUM_W - 1)) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      neg_r <= sample[SAMPLE_W-1];
      x_r   <= sample;
      mag_r <= mag;
      n_r   <= peak100 - DEN_W'({{(DEN_W-SAMPLE_W){1'b0}}, a_cl} * DEN_W'(99));
      if (cmd.kind == K_COMP) begin
        den_r  <= peak100 - KNEE_99;
        kind_r <= (mag < KNEE_Q) ? K_PASS : K_COMP;
      end else begin
        den_r  <= cmd.divisor;
        kind_r <= cmd.kind;
      end
    end
    if (state_r == S_MUL) begin
      if (kind_r == K_COMP) begin
        num_r <= NUM_W'(n_r * COMP_M) + NUM_W'(den_r >> 1);
      end else begin
        num_r <= (NUM_W'(mag_r) << FRAC_W) + NUM_W'(den_r >> 1);
      end
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r <= qbit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign y = SAMPLE_W'(ONE_Q) - num_r[SAMPLE_W-1:0];

  always_comb begin
    case (kind_r)
      K_CLIP: begin
        if (x_r > ONE_Q) result = ONE_Q;
        else if (x_r < -ONE_Q) result = -ONE_Q;
        else result = x_r;
      end
      K_ONE:  result = ONE_Q;
      K_DIV: begin
        if (!neg_r) begin
          result = (num_r > NUM_W'(SMAX)) ? SMAX : SAMPLE_W'(num_r);
        end else begin
          result = (num_r > NUM_W'(1 << (SAMPLE_W - 1))) ? SMIN :
                   SAMPLE_W'(-num_r[SAMPLE_W-1:0]);
        end
      end
      K_COMP: result = neg_r ? SAMPLE_W'(-y) : y;
      default: result = x_r;
    endcase
  end

  assign done = (state_r == S_DONE);

endmodule

### sv/audio_clipping_manager.sv
// Channel  Direction  Word
// in_      slave      tdata wave0, wave1, amp0, amp1; tuser action; tlast final frame
// out_     master     tdata wave0, wave1, amp0, amp1; tuser status; tlast last frame
// cfg_     APB        clip_mode at byte address 0
//
// A load, or any word that is refused, is held in the pending register and then reaches the output register
// once a waiting result is taken. The next word is then accepted in the cycle after.
// A read passes the RAMs, the lanes with their 50-step restoring divider and the pending register
// before it reaches the output register, and the next word is accepted in the cycle after.
// Reset is synchronous; it clears counters and peaks and sets the divisors to one; the store is not cleared.
// A result waiting on out_tready holds the block after the next item is processed.
module audio_clipping_manager import acm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [4*SAMPLE_W-1:0]     in_tdata,   // wave0, wave1, amp0, amp1
  input  logic                      in_tlast,
  input  logic                      in_tuser,   // action
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [4*SAMPLE_W-1:0]     out_tdata,  // wave0, wave1, amp0, amp1
  output logic                      out_tlast,
  output logic [1:0]                out_tuser,  // status
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_LANE = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [2:0]                 mode_r;
  logic [CNT_W-1:0]           fc_r;
  logic [CNT_W-1:0]           rp_r;
  logic signed [SAMPLE_W-1:0] apk_r [TRACKS];
  logic [SAMPLE_W-1:0]        wpk_r;
  logic signed [SAMPLE_W-1:0] sf_r [TRACKS+1];
  logic                       done_r;
  logic [4*SAMPLE_W-1:0]      pend_data_r;
  logic                       pend_last_r;
  logic [1:0]                 pend_status_r;
  logic                       out_valid_r;
  logic [4*SAMPLE_W-1:0]      out_data_r;
  logic                       out_last_r;
  logic [1:0]                 out_status_r;

  logic                       acc;
  logic                       do_load;
  logic                       finish;
  logic signed [SAMPLE_W-1:0] apk_nxt [TRACKS];
  logic [SAMPLE_W-1:0]        wpk_nxt;
  logic signed [SAMPLE_W-1:0] sf_nxt [TRACKS+1];
  logic signed [SAMPLE_W-1:0] top;
  logic [FRAME_W-1:0]         wave_wdata, amp_wdata, wave_rdata, amp_rdata;
  logic                       ram_re;
  logic signed [SUM_W-1:0]    amp_sum;
  lane_cmd_t                  cmd [LANES];
  logic signed [SAMPLE_W-1:0] lane_in [LANES];
  logic signed [SAMPLE_W-1:0] lane_out [LANES];
  logic [LANES-1:0]           lane_done;
  logic                       lane_start;

  assign acc        = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign do_load    = acc && (in_tuser == ACT_LOAD) && !done_r && (fc_r != CNT_W'(FRAMES));
  assign finish     = acc && (in_tuser == ACT_LOAD) && !done_r && in_tlast;
  assign ram_re     = acc && (in_tuser == ACT_READ) && done_r && (rp_r < fc_r);
  assign lane_start = (state_r == ST_RD);

  always_comb begin
    wpk_nxt = wpk_r;
    for (int t = 0; t < TRACKS; t++) begin
      logic signed [SAMPLE_W-1:0] wv;
      logic signed [SAMPLE_W-1:0] av;
      logic [SAMPLE_W-1:0]        mg;
      wv = in_tdata[t*SAMPLE_W +: SAMPLE_W];
      av = in_tdata[(TRACKS+t)*SAMPLE_W +: SAMPLE_W];
      mg = wv[SAMPLE_W-1] ? SAMPLE_W'(-wv) : wv;
      wave_wdata[t*SAMPLE_W +: SAMPLE_W] = wv;
      amp_wdata[t*SAMPLE_W +: SAMPLE_W]  = av;
      apk_nxt[t] = (do_load && av > apk_r[t]) ? av : apk_r[t];
      if (do_load && mg > wpk_nxt) wpk_nxt = mg;
    end
    top = '0;
    for (int t = 0; t < TRACKS; t++) begin
      sf_nxt[1+t] = (apk_nxt[t] > 0) ? apk_nxt[t] : ONE_Q;
      if (apk_nxt[t] > top) top = apk_nxt[t];
    end
    sf_nxt[0] = (top > 0) ? top : ONE_Q;
  end

  acm_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_wave_ram (
    .clk(clk), .we(do_load), .waddr(fc_r[ADDR_W-1:0]), .wdata(wave_wdata),
    .re(ram_re), .raddr(rp_r[ADDR_W-1:0]), .rdata(wave_rdata)
  );

  acm_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_amp_ram (
    .clk(clk), .we(do_load), .waddr(fc_r[ADDR_W-1:0]), .wdata(amp_wdata),
    .re(ram_re), .raddr(rp_r[ADDR_W-1:0]), .rdata(amp_rdata)
  );

  always_comb begin
    amp_sum = '0;
    for (int t = 0; t < TRACKS; t++) begin
      amp_sum = amp_sum + SUM_W'($signed(amp_rdata[t*SAMPLE_W +: SAMPLE_W]));
    end
    for (int i = 0; i < LANES; i++) begin
      logic is_amp;
      int   t;
      is_amp = (i >= TRACKS);
      t      = i % TRACKS;
      lane_in[i] = is_amp ? amp_rdata[t*SAMPLE_W +: SAMPLE_W]
                          : wave_rdata[t*SAMPLE_W +: SAMPLE_W];
      cmd[i].kind    = K_PASS;
      cmd[i].divisor = DEN_W'(unsigned'(ONE_Q));
      case (mode_r)
        MODE_CLIP:  cmd[i].kind = K_CLIP;
        MODE_SCALE: begin
          cmd[i].kind    = K_DIV;
          cmd[i].divisor = DEN_W'(unsigned'(sf_r[0]));
        end
        MODE_CHAN: begin
          cmd[i].kind    = K_DIV;
          cmd[i].divisor = DEN_W'(unsigned'(sf_r[1+t]));
        end
        MODE_ANTI: begin
          if (amp_sum > SUM_W'(ONE_Q)) begin
            cmd[i].kind    = K_DIV;
            cmd[i].divisor = DEN_W'(unsigned'(amp_sum));
          end
        end
        MODE_CHAN_ANTI: begin
          if (wpk_r > PEAK_LIMIT) cmd[i].kind = is_amp ? K_ONE : K_COMP;
        end
        default: cmd[i].kind = K_PASS;
      endcase
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    acm_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(lane_start), .cmd(cmd[i]),
      .sample(lane_in[i]), .peak(wpk_r), .done(lane_done[i]), .result(lane_out[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = ram_re ? ST_RD : ST_FIN;
      ST_RD:   state_nxt = ST_LANE;
      ST_LANE: if (&lane_done) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NONE;
      fc_r        <= '0;
      rp_r        <= '0;
      wpk_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TRACKS; t++) apk_r[t] <= '0;
      for (int t = 0; t <= TRACKS; t++) sf_r[t] <= ONE_Q;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
        mode_r <= cfg_pwdata[2:0];
      end
      wpk_r <= wpk_nxt;
      for (int t = 0; t < TRACKS; t++) apk_r[t] <= apk_nxt[t];
      if (do_load) fc_r <= fc_r + 1'b1;
      if (finish) begin
        done_r <= 1'b1;
        for (int t = 0; t <= TRACKS; t++) sf_r[t] <= sf_nxt[t];
      end
      if (state_r == ST_LANE && (&lane_done)) rp_r <= rp_r + 1'b1;
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && acc) begin
      pend_data_r <= '0;
      pend_last_r <= 1'b0;
      if (in_tuser == ACT_LOAD) begin
        pend_status_r <= do_load ? ST_ACCEPTED : ST_DROPPED;
      end else begin
        pend_status_r <= ST_EMPTY;
      end
    end
    if (state_r == ST_LANE && (&lane_done)) begin
      for (int i = 0; i < LANES; i++) pend_data_r[i*SAMPLE_W +: SAMPLE_W] <= lane_out[i];
      pend_last_r   <= (rp_r + 1'b1 == fc_r);
      pend_status_r <= ST_RETURNED;
    end
    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_data_r   <= pend_data_r;
      out_last_r   <= pend_last_r;
      out_status_r <= pend_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {29'd0, mode_r};

endmodule

### sv/acm_checker.sv
`include "assert_macros.svh"

module acm_checker import acm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [4*SAMPLE_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [1:0]            out_tuser
);

  `ACM_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled word changed")
  `ACM_ASSERT(a_zero_fields, out_tvalid && out_tuser != ST_RETURNED |-> out_tdata == '0 && !out_tlast, "non-frame word carries samples")
  `ACM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "word valid after reset")

endmodule

bind audio_clipping_manager acm_checker u_acm_checker (.*);
